// File: src/arbd_pkg.sv
// Package: shared types and codes for the adaptive Rice bitstream decoder.
package arbd_pkg;

	// Command codes carried in the input word
	localparam logic [2:0] CMD_CLEAR   = 3'd0;
	localparam logic [2:0] CMD_PUSH    = 3'd1;
	localparam logic [2:0] CMD_RAW     = 3'd2;
	localparam logic [2:0] CMD_RICE    = 3'd3;
	localparam logic [2:0] CMD_SRICE   = 3'd4;
	localparam logic [2:0] CMD_DCRICE  = 3'd5;
	localparam logic [2:0] CMD_SDCRICE = 3'd6;

	// Status codes returned with every result word
	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_SHORT = 3'd1;
	localparam logic [2:0] ST_QLONG = 3'd2;
	localparam logic [2:0] ST_WIDE  = 3'd3;
	localparam logic [2:0] ST_FULL  = 3'd4;

	// Limits that do not vary
	localparam logic [4:0] RAW_MAX = 5'd16;
	localparam logic [3:0] K_MAX   = 4'd15;

	// Operation kinds after classification
	typedef logic [2:0] op_kind_t;
	localparam op_kind_t OP_NOP   = 3'd0;
	localparam op_kind_t OP_CLEAR = 3'd1;
	localparam op_kind_t OP_PUSH  = 3'd2;
	localparam op_kind_t OP_RAW   = 3'd3;
	localparam op_kind_t OP_RICE  = 3'd4;

	typedef struct packed {
		logic [2:0] cmd;
		logic [7:0] data_byte;
		logic [4:0] bit_count;
		logic [3:0] k_in;
	} item_t;

	typedef struct packed {
		logic signed [24:0] value;
		logic [3:0]         k_out;
		logic [2:0]         status;
		logic [6:0]         bits_held;
	} result_t;

	// Classified operation passed from front to back
	typedef struct packed {
		op_kind_t   kind;
		logic       dc;
		logic       sgn;
		logic [4:0] count;
		logic [7:0] data_byte;
		logic [3:0] k;
	} op_t;

endpackage

// File: src/adaptive_rice_bitstream_decoder.sv
// Top level: adaptive Rice bitstream decoder with front, queue and back stages.
//
// The decoder takes one command word per cycle unless stalled and returns one
// result word per command, in order. A word passes the front register, the
// operation queue and the back stage's result register; a stall can hold it
// in any of them. The back stage sets the sustained rate of one word per cycle
// when nothing stalls: for each word it takes, it updates the bit buffer with
// a leading-ones count over MAX_QUOTIENT+1 head bits followed by a barrel shift
// of the whole buffer. Stalls on the result side fill the queue and then reach
// the input after QUEUE_DEPTH+2 words. No clearing pass is needed after reset.
module adaptive_rice_bitstream_decoder #(
	parameter int BUFFER_BITS     = 64,
	parameter int MAX_QUOTIENT    = 32,
	parameter int MAX_ESCAPE_BITS = 24,
	parameter int QUEUE_DEPTH     = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  arbd_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output arbd_pkg::result_t result
);
	import arbd_pkg::*;

	logic fr_valid;
	logic fr_stall;
	op_t  fr_op;
	logic bk_valid;
	logic bk_stall;
	op_t  bk_op;

	arbd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.op_valid   (fr_valid),
		.op_stall   (fr_stall),
		.op         (fr_op)
	);

	arbd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fr_valid),
		.push_stall (fr_stall),
		.push_data  (fr_op),
		.pop_valid  (bk_valid),
		.pop_stall  (bk_stall),
		.pop_data   (bk_op)
	);

	arbd_back #(
		.BUFFER_BITS     (BUFFER_BITS),
		.MAX_QUOTIENT    (MAX_QUOTIENT),
		.MAX_ESCAPE_BITS (MAX_ESCAPE_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.op_valid     (bk_valid),
		.op_stall     (bk_stall),
		.op           (bk_op),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

// File: src/arbd_front.sv
// Front stage: accepts input words and classifies commands into operations.
module arbd_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_stall,
	input  arbd_pkg::item_t item,
	output logic           op_valid,
	input  logic           op_stall,
	output arbd_pkg::op_t  op
);
	import arbd_pkg::*;

	logic valid_s1;
	op_t  op_s1;
	op_t  op_d;
	logic load;

	assign load       = !valid_s1 || !op_stall;
	assign item_stall = !load;
	assign op_valid   = valid_s1;
	assign op         = op_s1;

	// Decode the command and saturate the raw count
	always_comb begin
		op_d           = '0;
		op_d.data_byte = item.data_byte;
		op_d.k         = item.k_in;
		op_d.count     = (item.bit_count > RAW_MAX) ? RAW_MAX : item.bit_count;
		case (item.cmd)
			CMD_CLEAR:   op_d.kind = OP_CLEAR;
			CMD_PUSH:    op_d.kind = OP_PUSH;
			CMD_RAW:     op_d.kind = OP_RAW;
			CMD_RICE:    op_d.kind = OP_RICE;
			CMD_SRICE: begin
				op_d.kind = OP_RICE;
				op_d.sgn  = 1'b1;
			end
			CMD_DCRICE: begin
				op_d.kind = OP_RICE;
				op_d.dc   = 1'b1;
			end
			CMD_SDCRICE: begin
				op_d.kind = OP_RICE;
				op_d.dc   = 1'b1;
				op_d.sgn  = 1'b1;
			end
			default:     op_d.kind = OP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && item_valid) begin
			op_s1 <= op_d;
		end
	end

endmodule

// File: src/arbd_queue.sv
// Queue: short register FIFO of classified operations between front and back.
module arbd_queue #(
	parameter int DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_stall,
	input  arbd_pkg::op_t push_data,
	output logic          pop_valid,
	input  logic          pop_stall,
	output arbd_pkg::op_t pop_data
);
	import arbd_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	op_t           mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          push;
	logic          pop;

	assign push_stall = (count_q == CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && !push_stall;
	assign pop        = pop_valid && !pop_stall;
	assign pop_data   = mem_q[rd_ptr_q];

	// Pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= CW'(count_q + CW'(push) - CW'(pop));
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue occupancy above depth");

endmodule

// File: src/arbd_back.sv
// Back stage: holds the bit buffer, executes operations, registers results.
module arbd_back #(
	parameter int BUFFER_BITS     = 64,
	parameter int MAX_QUOTIENT    = 32,
	parameter int MAX_ESCAPE_BITS = 24
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              op_valid,
	output logic              op_stall,
	input  arbd_pkg::op_t     op,
	output logic              result_valid,
	input  logic              result_stall,
	output arbd_pkg::result_t result
);
	import arbd_pkg::*;

	localparam int FW  = $clog2(BUFFER_BITS + 1);
	localparam int QW  = MAX_QUOTIENT + 1;
	localparam int QCW = $clog2(QW + 1);
	localparam int SW  = ((FW > 10) ? FW : 10) + 1;
	localparam int EXW = MAX_ESCAPE_BITS;

	logic [BUFFER_BITS-1:0] buf_q;
	logic [FW-1:0]          fill_q;
	logic                   result_valid_q;
	result_t                result_q;
	logic                   take;

	logic [QW-1:0]          head;
	logic [QCW-1:0]         q;
	logic [2:0]             lg;
	logic [BUFFER_BITS-1:0] sh_q1;
	logic [14:0]            rem;
	logic [EXW-1:0]         esc;
	logic [15:0]            raw;
	logic [SW-1:0]          qx;
	logic [SW-1:0]          kx;
	logic [SW-1:0]          fx;
	logic [SW-1:0]          n;
	logic [SW-1:0]          w;
	logic [SW-1:0]          nk;
	logic                   is_esc;
	logic [3:0]             k_esc;
	logic [3:0]             k_next;
	logic [4:0]             k_sum;
	logic [24:0]            rice_val;

	logic [2:0]             status;
	logic [24:0]            val;
	logic [3:0]             kout;
	logic [SW-1:0]          cons;
	logic [BUFFER_BITS-1:0] nbuf;
	logic [FW-1:0]          nfill;
	result_t                res_d;

	assign take         = op_valid && !op_stall;
	assign op_stall     = result_valid_q && result_stall;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Leading-ones count at the buffer head
	assign head = buf_q[BUFFER_BITS-1 -: QW];
	always_comb begin
		q = QCW'(QW);
		for (int i = 0; i < QW; i++) begin
			if (!head[i]) q = QCW'(QW - 1 - i);
		end
	end

	// floor(log2 q) for the k update
	always_comb begin
		lg = '0;
		for (int i = 0; i < QCW; i++) begin
			if (q[i]) lg = 3'(i);
		end
	end

	// Field extraction after the unary run and its terminator
	assign sh_q1 = buf_q << ({1'b0, q} + (QCW + 1)'(1));
	assign rem   = sh_q1[BUFFER_BITS-1 -: 15] >> (K_MAX - op.k);
	assign raw   = buf_q[BUFFER_BITS-1 -: 16] >> (RAW_MAX - op.count);

	assign qx     = SW'(q);
	assign kx     = SW'(op.k);
	assign fx     = SW'(fill_q);
	assign is_esc = op.dc && (qx >= kx + SW'(8));
	assign n      = qx - SW'(7) - kx;
	assign w      = SW'(n * (kx + SW'(5)));
	assign esc    = sh_q1[BUFFER_BITS-1 -: EXW] >> (SW'(EXW) - w);
	assign nk     = kx + (n << 1);
	assign k_esc  = (nk > SW'(K_MAX)) ? K_MAX : nk[3:0];

	// Adaptive k after a regular code
	assign k_sum = 5'(op.k) + 5'(lg);
	always_comb begin
		if (q == '0) begin
			k_next = (op.k == '0) ? '0 : op.k - 1'b1;
		end else if (q == QCW'(1)) begin
			k_next = op.k;
		end else begin
			k_next = (k_sum > 5'(K_MAX)) ? K_MAX : k_sum[3:0];
		end
	end

	assign rice_val = (25'(q) << op.k) | 25'(rem);

	// Execute one operation against the buffer
	always_comb begin
		status = ST_OK;
		val    = '0;
		kout   = op.k;
		cons   = '0;
		nbuf   = buf_q;
		nfill  = fill_q;
		case (op.kind)
			OP_CLEAR: begin
				nbuf  = '0;
				nfill = '0;
			end
			OP_PUSH: begin
				if (fx + SW'(8) > SW'(BUFFER_BITS)) begin
					status = ST_FULL;
				end else begin
					nbuf  = buf_q | ({op.data_byte, {(BUFFER_BITS - 8){1'b0}}} >> fill_q);
					nfill = fill_q + FW'(8);
				end
			end
			OP_RAW: begin
				if (SW'(op.count) > fx) begin
					status = ST_SHORT;
				end else begin
					val  = 25'(raw);
					cons = SW'(op.count);
				end
			end
			OP_RICE: begin
				if (q == QCW'(QW)) begin
					status = ST_QLONG;
				end else if (qx >= fx) begin
					status = ST_SHORT;
				end else if (is_esc) begin
					if (w > SW'(EXW)) begin
						status = ST_WIDE;
					end else if (qx + SW'(1) + w > fx) begin
						status = ST_SHORT;
					end else begin
						val  = 25'(esc);
						kout = k_esc;
						cons = qx + SW'(1) + w;
					end
				end else if (qx + SW'(1) + kx > fx) begin
					status = ST_SHORT;
				end else begin
					val  = rice_val;
					kout = k_next;
					cons = qx + SW'(1) + kx;
				end
				// zigzag mapping for the signed forms
				if (status == ST_OK && op.sgn) begin
					val = {1'b0, val[24:1]} ^ {25{val[0]}};
				end
			end
			default: ;
		endcase
		if (cons != '0) begin
			nbuf  = buf_q << cons;
			nfill = fill_q - cons[FW-1:0];
		end
	end

	always_comb begin
		res_d.value     = signed'(val);
		res_d.k_out     = kout;
		res_d.status    = status;
		res_d.bits_held = 7'(nfill);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q          <= '0;
			fill_q         <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (take) begin
				buf_q  <= nbuf;
				fill_q <= nfill;
			end
			if (!op_stall) begin
				result_valid_q <= op_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			result_q <= res_d;
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(BUFFER_BITS))
		else $error("buffer fill above capacity");

	a_tail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(buf_q << fill_q) == '0)
		else $error("stale bits past the buffer fill");

	a_fail_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		take && res_d.status != ST_OK |=> $stable(fill_q) && $stable(buf_q))
		else $error("failed word changed the buffer");

endmodule

// File: dv/arbd_checker.sv
// Checker for the adaptive Rice decoder: bit-buffer predictor plus in-order result compare.
`timescale 1ns / 100ps

module arbd_checker #(
	parameter int BUFFER_BITS     = 64,
	parameter int MAX_QUOTIENT    = 32,
	parameter int MAX_ESCAPE_BITS = 24
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  logic              item_stall,
	input  arbd_pkg::item_t   item,
	input  logic              result_valid,
	input  logic              result_stall,
	input  arbd_pkg::result_t result,
	output int                errors,
	output int                pending,
	output int                taken,
	output int                checked,
	output int                escapes,
	output int                refusals
);
	import arbd_pkg::*;

	// Predicted buffer: head bit sits at the MSB, bits past the fill are zero
	logic [BUFFER_BITS-1:0] held_bits;
	int                     held_count;
	result_t                due_q[$];

	// Collect count bits from position start, first bit ends up most significant
	function automatic logic [31:0] peek_bits(input int start, input int count);
		logic [31:0] acc;
		int          p;
		acc = '0;
		for (int i = 0; i < count; i++) begin
			p = start + i;
			acc = {acc[30:0], (p < held_count) ? held_bits[BUFFER_BITS-1-p] : 1'b0};
		end
		return acc;
	endfunction

	// Apply one command word to the predicted buffer and return its answer
	function automatic result_t decode_word(input item_t w, output bit escaped);
		result_t     r;
		logic [31:0] val;
		logic [2:0]  st;
		int          k, kout, q, n, width, cnt, used;
		val = '0;
		k = int'(w.k_in);
		kout = k;
		st = ST_OK;
		used = 0;
		escaped = 1'b0;
		case (w.cmd)
			CMD_CLEAR: begin
				held_bits = '0;
				held_count = 0;
			end
			CMD_PUSH: begin
				if (held_count + 8 > BUFFER_BITS) begin
					st = ST_FULL;
				end else begin
					held_bits[BUFFER_BITS-1-held_count -: 8] = w.data_byte;
					held_count += 8;
				end
			end
			CMD_RAW: begin
				cnt = (w.bit_count > RAW_MAX) ? int'(RAW_MAX) : int'(w.bit_count);
				if (cnt > held_count) begin
					st = ST_SHORT;
				end else begin
					val = peek_bits(0, cnt);
					used = cnt;
				end
			end
			CMD_RICE, CMD_SRICE, CMD_DCRICE, CMD_SDCRICE: begin
				// unary run, stopping one past the quotient limit
				q = 0;
				while (q < held_count && q <= MAX_QUOTIENT && held_bits[BUFFER_BITS-1-q])
					q++;
				if (q > MAX_QUOTIENT) begin
					st = ST_QLONG;
				end else if (q >= held_count) begin
					st = ST_SHORT;
				end else if ((w.cmd == CMD_DCRICE || w.cmd == CMD_SDCRICE) && q >= 8 + k) begin
					// DC escape: payload of n*(5+k) raw bits
					n = q - 7 - k;
					width = n * (5 + k);
					if (width > MAX_ESCAPE_BITS) begin
						st = ST_WIDE;
					end else if (q + 1 + width > held_count) begin
						st = ST_SHORT;
					end else begin
						val = peek_bits(q + 1, width);
						kout = (k + 2 * n > int'(K_MAX)) ? int'(K_MAX) : k + 2 * n;
						used = q + 1 + width;
						escaped = 1'b1;
					end
				end else if (q + 1 + k > held_count) begin
					st = ST_SHORT;
				end else begin
					val = (q << k) | peek_bits(q + 1, k);
					used = q + 1 + k;
					// k adapts: down on q=0, hold on q=1, up by log2 q beyond
					if (q == 0) begin
						kout = (k > 0) ? k - 1 : 0;
					end else begin
						kout = k;
						for (n = q; n > 1; n = n >> 1)
							kout++;
						if (kout > int'(K_MAX))
							kout = int'(K_MAX);
					end
				end
				if (st == ST_OK && (w.cmd == CMD_SRICE || w.cmd == CMD_SDCRICE))
					val = (val >> 1) ^ (32'd0 - {31'd0, val[0]});
			end
			default: ;
		endcase
		held_bits = held_bits << used;
		held_count -= used;
		r.value = val[24:0];
		r.k_out = kout[3:0];
		r.status = st;
		r.bits_held = held_count[6:0];
		return r;
	endfunction

	// Report one field; returns 1 on mismatch
	function automatic int field_off(input string name, input logic signed [31:0] want,
			input logic signed [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			return 1;
		end
		return 0;
	endfunction

	// Predict on each accepted command word, compare on each accepted result word
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		bit      hit_escape;
		int      bad;
		if (!arst_n) begin
			held_bits = '0;
			held_count = 0;
			due_q.delete();
			errors <= 0;
			pending <= 0;
			taken <= 0;
			checked <= 0;
			escapes <= 0;
			refusals <= 0;
		end else begin
			bad = 0;
			if (item_valid && !item_stall) begin
				want = decode_word(item, hit_escape);
				due_q.push_back(want);
				taken <= taken + 1;
				if (hit_escape)
					escapes <= escapes + 1;
				if (want.status != ST_OK)
					refusals <= refusals + 1;
			end
			if (result_valid && !result_stall) begin
				if (due_q.size() == 0) begin
					$display("%0t: result word with nothing expected, expected none, actual %p",
						$time, result);
					bad = 1;
				end else begin
					want = due_q.pop_front();
					bad += field_off("value", 32'(want.value), 32'(result.value));
					bad += field_off("k_out", 32'(want.k_out), 32'(result.k_out));
					bad += field_off("status", 32'(want.status), 32'(result.status));
					bad += field_off("bits_held", 32'(want.bits_held),
						32'(result.bits_held));
					checked <= checked + 1;
				end
			end
			errors <= errors + bad;
			pending <= due_q.size();
		end
	end

endmodule

// File: dv/tb_adaptive_rice_bitstream_decoder.sv
// Testbench top for the adaptive Rice decoder: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_adaptive_rice_bitstream_decoder;
	import arbd_pkg::*;

	localparam int BUFFER_BITS     = 64;
	localparam int MAX_QUOTIENT    = 32;
	localparam int MAX_ESCAPE_BITS = 24;
	localparam int WORD_TARGET     = 1925;
	// cycle window where neither side pauses
	localparam int QUIET_FROM      = 1200;
	localparam int QUIET_TO        = 2200;
	localparam logic [2:0] CMD_SPARE = 3'd7;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_stall;
	item_t   item = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	item_t words_q[$];
	int    issued = 0;
	int    cyc = 0;
	int    directed_n;
	int    errors, pending, taken, checked, escapes, refusals;

	adaptive_rice_bitstream_decoder #(
		.BUFFER_BITS    (BUFFER_BITS),
		.MAX_QUOTIENT   (MAX_QUOTIENT),
		.MAX_ESCAPE_BITS(MAX_ESCAPE_BITS)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

	arbd_checker #(
		.BUFFER_BITS    (BUFFER_BITS),
		.MAX_QUOTIENT   (MAX_QUOTIENT),
		.MAX_ESCAPE_BITS(MAX_ESCAPE_BITS)
	) u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result),
		.errors      (errors),
		.pending     (pending),
		.taken       (taken),
		.checked     (checked),
		.escapes     (escapes),
		.refusals    (refusals)
	);

	always #6 clk = ~clk;

	// Random pause, taken with a chance of 37 in 100 outside the quiet window
	function automatic bit pause_now();
		return (cyc < QUIET_FROM || cyc >= QUIET_TO) && $urandom_range(99) < 37;
	endfunction

	task automatic add_word(input logic [2:0] op, input logic [7:0] b, input logic [4:0] cnt,
			input logic [3:0] k);
		item_t w;
		w.cmd = op;
		w.data_byte = b;
		w.bit_count = cnt;
		w.k_in = k;
		words_q.push_back(w);
	endtask

	// Command side: a new word only once the previous one is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			item <= '0;
			issued <= 0;
			cyc <= 0;
		end else begin
			cyc <= cyc + 1;
			if (!item_valid || !item_stall) begin
				if (issued < words_q.size() && !pause_now()) begin
					item_valid <= 1'b1;
					item <= words_q[issued];
					issued <= issued + 1;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// Result side back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_stall <= 1'b0;
		else
			result_stall <= pause_now();
	end

	initial begin : stimulus
		bit         code_bits[$];
		logic [7:0] b;
		logic [2:0] op;
		int         nsym, kind, k, q, n, w, need, avail, pad, cnt;

		// Directed: raw read of zero bits on an empty buffer, then decode with nothing held
		add_word(CMD_RAW, 8'($urandom), 5'd0, 4'($urandom));
		add_word(CMD_RICE, 8'($urandom), 5'($urandom), 4'd0);
		// 40 ones: quotient past the limit
		repeat (5) add_word(CMD_PUSH, 8'hFF, 5'($urandom), 4'($urandom));
		add_word(CMD_RICE, 8'($urandom), 5'($urandom), 4'd0);
		// raw count above 16 saturates
		add_word(CMD_RAW, 8'($urandom), 5'd31, 4'($urandom));
		// run of 32 ones with no terminating zero
		add_word(CMD_PUSH, 8'hFF, 5'($urandom), 4'($urandom));
		add_word(CMD_SRICE, 8'($urandom), 5'($urandom), 4'd5);
		// fill to 64 bits, then one push too many
		repeat (4) add_word(CMD_PUSH, 8'hFF, 5'($urandom), 4'($urandom));
		add_word(CMD_PUSH, 8'h55, 5'($urandom), 4'($urandom));
		add_word(CMD_SPARE, 8'($urandom), 5'($urandom), 4'($urandom));
		// signed DC escape at k=0: eight ones, zero, five payload bits
		add_word(CMD_CLEAR, 8'($urandom), 5'($urandom), 4'($urandom));
		add_word(CMD_PUSH, 8'hFF, 5'($urandom), 4'($urandom));
		add_word(CMD_PUSH, 8'h58, 5'($urandom), 4'($urandom));
		add_word(CMD_SDCRICE, 8'($urandom), 5'($urandom), 4'd0);
		// q=0 at k=15, all-ones remainder
		add_word(CMD_CLEAR, 8'($urandom), 5'($urandom), 4'($urandom));
		add_word(CMD_PUSH, 8'h7F, 5'($urandom), 4'($urandom));
		add_word(CMD_PUSH, 8'hFF, 5'($urandom), 4'($urandom));
		add_word(CMD_RICE, 8'($urandom), 5'($urandom), 4'd15);
		// escape whose payload is wider than allowed
		add_word(CMD_PUSH, 8'hFF, 5'($urandom), 4'($urandom));
		add_word(CMD_PUSH, 8'hFE, 5'($urandom), 4'($urandom));
		add_word(CMD_DCRICE, 8'($urandom), 5'($urandom), 4'd3);
		directed_n = words_q.size();

		// Random: mostly well-formed coded runs, the rest noise and broken sequences
		while (words_q.size() < WORD_TARGET) begin
			if ($urandom_range(99) < 80) begin
				add_word(CMD_CLEAR, 8'($urandom), 5'($urandom), 4'($urandom));
				code_bits.delete();
				avail = 0;
				pad = 0;
				nsym = $urandom_range(1, 12);
				repeat (nsym) begin
					// drop filler bits left by the last byte
					if (pad > 0) begin
						add_word(CMD_RAW, 8'($urandom), 5'(pad), 4'($urandom));
						avail -= pad;
						pad = 0;
					end
					kind = $urandom_range(0, 4);
					k = $urandom_range(0, 15);
					cnt = $urandom_range(0, 31);
					if (kind == 0) begin
						op = CMD_RAW;
						need = $urandom_range(0, RAW_MAX);
						cnt = (need == RAW_MAX) ? $urandom_range(RAW_MAX, 31) : need;
						repeat (need) code_bits.push_back(1'($urandom_range(0, 1)));
					end else begin
						if (kind <= 2) begin
							op = (kind == 1) ? CMD_RICE : CMD_SRICE;
							case ($urandom_range(0, 9))
								0, 1, 2, 3, 4, 5: q = $urandom_range(0, 3);
								6, 7, 8: q = $urandom_range(0, 12);
								default: q = $urandom_range(0, MAX_QUOTIENT);
							endcase
							w = k;
						end else begin
							op = (kind == 3) ? CMD_DCRICE : CMD_SDCRICE;
							if ($urandom_range(0, 1)) begin
								n = $urandom_range(1, MAX_ESCAPE_BITS / (5 + k));
								q = 7 + k + n;
								w = n * (5 + k);
							end else begin
								q = $urandom_range(0, 7 + k);
								w = k;
							end
						end
						repeat (q) code_bits.push_back(1'b1);
						code_bits.push_back(1'b0);
						repeat (w) code_bits.push_back(1'($urandom_range(0, 1)));
						need = q + 1 + w;
					end
					// push bytes until the whole code is held, padding past its end
					while (avail < need) begin
						b = '0;
						for (int i = 0; i < 8; i++) begin
							if (code_bits.size() == 0) begin
								code_bits.push_back(1'($urandom_range(0, 1)));
								pad++;
							end
							b = {b[6:0], code_bits.pop_front()};
						end
						add_word(CMD_PUSH, b, 5'($urandom), 4'($urandom));
						avail += 8;
					end
					add_word(op, 8'($urandom), 5'(cnt), 4'(k));
					avail -= need;
				end
			end else begin
				case ($urandom_range(0, 2))
					0: repeat ($urandom_range(1, 8))
						add_word(3'($urandom_range(0, 7)), 8'($urandom), 5'($urandom),
							4'($urandom));
					1: begin
						// long runs of ones, often past the quotient limit or the buffer
						repeat ($urandom_range(4, 9))
							add_word(CMD_PUSH, $urandom_range(0, 1) ? 8'hFF : 8'($urandom),
								5'($urandom), 4'($urandom));
						add_word(3'($urandom_range(CMD_RICE, CMD_SDCRICE)), 8'($urandom),
							5'($urandom), 4'($urandom));
					end
					default: begin
						// truncated code
						add_word(CMD_CLEAR, 8'($urandom), 5'($urandom), 4'($urandom));
						repeat ($urandom_range(1, 3))
							add_word(CMD_PUSH, 8'($urandom), 5'($urandom), 4'($urandom));
						add_word(3'($urandom_range(CMD_RAW, CMD_SDCRICE)), 8'($urandom),
							5'($urandom), 4'($urandom));
					end
				endcase
			end
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Drain: every word taken, every result back, then a short quiet tail
		while (taken < words_q.size()) @(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("Covered %0d command words (%0d directed), %0d results compared.",
			taken, directed_n, checked);
		$display("%0d escape codes decoded, %0d words answered with a non-ok status.",
			escapes, refusals);
		if (errors == 0 && pending == 0)
			$display("[adaptive_rice_bitstream_decoder] OK");
		else
			$display("[adaptive_rice_bitstream_decoder] ERROR");
		$finish;
	end

	// Watchdog
	initial begin
		#1200000;
		$display("Timeout with %0d results still outstanding.", pending);
		$display("[adaptive_rice_bitstream_decoder] ERROR");
		$finish;
	end

endmodule
